[design/rmta_pkg.sv]
// Package for the two-angle rotation matrix block: payload types, angle
// constants, the Q15 multiply and the quarter-wave sine table built at elaboration.
// No dependencies.
package rmta_pkg;

    localparam int DEGREE_STEPS     = 360;
    localparam int QUADRANT_ENTRIES = 91;
    localparam int QUADRANT_W       = 7;
    localparam int ANGLE_W          = 9;
    localparam int Q15_W            = 16;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 9'd90;
    localparam logic [ANGLE_W-1:0] HALF_TURN          = 9'd180;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 9'd270;
    localparam logic [ANGLE_W-1:0] FULL_TURN          = 9'd360;
    localparam logic signed [Q15_W-1:0] Q15_ONE       = 16'sd32767;

    typedef logic [ANGLE_W-1:0]        angle_t;
    typedef logic signed [Q15_W-1:0]   q15_t;

    // Sine and cosine of both angles for one transaction.
    typedef struct packed {
        q15_t sin_x;
        q15_t cos_x;
        q15_t sin_y;
        q15_t cos_y;
    } trig_t;

    // The nine entries of the product matrix, row major.
    typedef struct packed {
        q15_t m00;
        q15_t m01;
        q15_t m02;
        q15_t m10;
        q15_t m11;
        q15_t m12;
        q15_t m20;
        q15_t m21;
        q15_t m22;
    } matrix_t;

    // Sines of 0..90 degrees; the other quadrants follow by symmetry.
    typedef logic [QUADRANT_ENTRIES-1:0][Q15_W-1:0] sine_table_t;

    // Constants of the fixed-point Taylor series used to build the table.
    localparam int          FRAC_BITS = 30;
    localparam logic [63:0] PI_E15    = 64'd3141592653589793;
    localparam logic [63:0] E6        = 64'd1000000;
    localparam logic [63:0] E9        = 64'd1000000000;
    localparam logic [63:0] HALF_DEG  = 64'd180;
    localparam logic [7:0][15:0] SERIES_DIV = {
        16'd272, 16'd210, 16'd156, 16'd110, 16'd72, 16'd42, 16'd20, 16'd6
    };

    // Sine of d degrees (0..90) in unsigned Q30.
    function automatic logic [63:0] first_quadrant_sine(input int unsigned d);
        logic [63:0] q;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        q  = (64'(d) * PI_E15) / HALF_DEG;
        hi = q / E6;
        lo = q % E6;
        x  = ((hi << FRAC_BITS) + ((lo << FRAC_BITS) / E6)) / E9;
        x2 = (x * x) >> FRAC_BITS;
        term = x;
        pos  = x;
        neg  = '0;
        for (int n = 0; n < 8; n++) begin
            term = ((term * x2) >> FRAC_BITS) / 64'(SERIES_DIV[n]);
            if ((n % 2) == 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    // Rounded 32767 * sin(d degrees) for d in 0..359.
    function automatic logic [Q15_W-1:0] rom_value(input int unsigned d);
        int unsigned r;
        logic        negate;
        logic [63:0] s;
        logic [63:0] mag;
        negate = 1'b0;
        if (d <= 90) begin
            r = d;
        end else if (d <= 180) begin
            r = 180 - d;
        end else if (d <= 270) begin
            r = d - 180;
            negate = 1'b1;
        end else begin
            r = 360 - d;
            negate = 1'b1;
        end
        s   = first_quadrant_sine(r);
        mag = (s * 64'd32767 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return negate ? (16'd0 - mag[Q15_W-1:0]) : mag[Q15_W-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        for (int d = 0; d < QUADRANT_ENTRIES; d++) begin
            tbl[d] = rom_value(d);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    // Q15 product: floor(a * b / 2^15), kept to 16 bits.
    function automatic q15_t q15_mul(input logic signed [Q15_W:0] a,
                                     input logic signed [Q15_W:0] b);
        logic signed [2*Q15_W+1:0] p;
        p = a * b;
        return p[Q15_W+14:15];
    endfunction

endpackage

[design/rmta_lookup.sv]
// Angle reduction and sine/cosine lookup for both angles.
// Depends on rmta_pkg (types, constants, SINE_TABLE).
module rmta_lookup (
    input  rmta_pkg::angle_t angle_x,
    input  rmta_pkg::angle_t angle_y,
    output rmta_pkg::trig_t  trig
);
    import rmta_pkg::*;

    angle_t ax;
    angle_t ay;

    // Sine of an angle of 0..359 from the quarter-wave table.
    function automatic q15_t sine_of(input angle_t a);
        angle_t idx;
        logic   negate;
        q15_t   mag;
        negate = 1'b0;
        if (a <= QUARTER_TURN)
        begin
            idx = a;
        end
        else if (a <= HALF_TURN)
        begin
            idx = HALF_TURN - a;
        end
        else if (a <= THREE_QUARTER_TURN)
        begin
            idx    = a - HALF_TURN;
            negate = 1'b1;
        end
        else
        begin
            idx    = FULL_TURN - a;
            negate = 1'b1;
        end
        mag = q15_t'(SINE_TABLE[idx[QUADRANT_W-1:0]]);
        return negate ? -mag : mag;
    endfunction

    // Cosine of an angle of 0..359, read as the sine of 90 minus the angle.
    function automatic q15_t cosine_of(input angle_t a);
        angle_t idx;
        logic   negate;
        q15_t   mag;
        negate = 1'b0;
        if (a <= QUARTER_TURN)
        begin
            idx = QUARTER_TURN - a;
        end
        else if (a <= HALF_TURN)
        begin
            idx    = a - QUARTER_TURN;
            negate = 1'b1;
        end
        else if (a <= THREE_QUARTER_TURN)
        begin
            idx    = THREE_QUARTER_TURN - a;
            negate = 1'b1;
        end
        else
        begin
            idx = a - THREE_QUARTER_TURN;
        end
        mag = q15_t'(SINE_TABLE[idx[QUADRANT_W-1:0]]);
        return negate ? -mag : mag;
    endfunction

    // Angles of 360 and above are taken modulo 360.
    always_comb
    begin
        ax  = (angle_x >= FULL_TURN) ? (angle_x - FULL_TURN) : angle_x;
        ay  = (angle_y >= FULL_TURN) ? (angle_y - FULL_TURN) : angle_y;
        trig.sin_x = sine_of(ax);
        trig.cos_x = cosine_of(ax);
        trig.sin_y = sine_of(ay);
        trig.cos_y = cosine_of(ay);
    end

endmodule

[design/rmta_product.sv]
// Product of the X and Y rotation matrices from the looked-up sines and cosines.
// Depends on rmta_pkg (trig_t, matrix_t, q15_mul).
module rmta_product (
    input  rmta_pkg::trig_t   trig,
    output rmta_pkg::matrix_t mat
);
    import rmta_pkg::*;

    logic signed [Q15_W:0] sx;
    logic signed [Q15_W:0] cx;
    logic signed [Q15_W:0] sy;
    logic signed [Q15_W:0] cy;
    logic signed [Q15_W:0] one;

    // Terms with a zero factor vanish: each entry is zero or one Q15 product.
    // Negations are applied to the operands because the floor is not odd.
    always_comb
    begin
        sx  = {trig.sin_x[Q15_W-1], trig.sin_x};
        cx  = {trig.cos_x[Q15_W-1], trig.cos_x};
        sy  = {trig.sin_y[Q15_W-1], trig.sin_y};
        cy  = {trig.cos_y[Q15_W-1], trig.cos_y};
        one = {Q15_ONE[Q15_W-1], Q15_ONE};
        mat.m00 = q15_mul(one, cy);
        mat.m01 = '0;
        mat.m02 = q15_mul(one, sy);
        mat.m10 = q15_mul(-sx, -sy);
        mat.m11 = q15_mul(cx, one);
        mat.m12 = q15_mul(-sx, cy);
        mat.m20 = q15_mul(cx, -sy);
        mat.m21 = q15_mul(sx, one);
        mat.m22 = q15_mul(cx, cy);
    end

endmodule

[design/rotation_matrix_two_angles.sv]
// Top level of the two-angle Q15 rotation matrix block.
// Depends on rmta_pkg, rmta_lookup and rmta_product.
//
// Usage:
// An input transaction carries two whole-degree angles, angle_x and angle_y.
// For each one the block emits one output transaction with the nine entries
// of M = X * Y, where X rotates about the x axis and Y about the y axis,
// each entry a signed Q15 value with 32767 standing for one. Angles of
// 360 to 511 are taken modulo 360.
// Both channels use valid/stall: a transaction moves at a rising edge where
// valid is high and stall is low.
// Output valid rises when the result register loads. The angles land in an
// input register at the accepting edge; the sine lookup and at most one Q15
// multiply per entry, run as a single combinational step, then load the result
// register at an edge where it is empty or being drained. That single step
// sets a throughput of one transaction per cycle while out_stall is low.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, and in_stall rises only when both
// registers are full and the output is stalled.
// Reset (rst_n low, asynchronous) empties both registers; the sine table is
// a constant and needs no initialization.
module rotation_matrix_two_angles (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rmta_pkg::angle_t angle_x,
    input  rmta_pkg::angle_t angle_y,
    output logic             out_valid,
    input  logic             out_stall,
    output rmta_pkg::q15_t   m00,
    output rmta_pkg::q15_t   m01,
    output rmta_pkg::q15_t   m02,
    output rmta_pkg::q15_t   m10,
    output rmta_pkg::q15_t   m11,
    output rmta_pkg::q15_t   m12,
    output rmta_pkg::q15_t   m20,
    output rmta_pkg::q15_t   m21,
    output rmta_pkg::q15_t   m22
);
    import rmta_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    angle_t  angle_x_reg;
    angle_t  angle_y_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    matrix_t mat_reg;

    logic    out_adv;
    logic    in_adv;
    trig_t   trig;
    matrix_t mat;

    // The result register loads whenever it is empty or being drained.
    // The input register loads whenever it is empty or moving on.
    assign out_adv  = !out_valid_reg || !out_stall;
    assign in_adv   = !in_valid_reg || out_adv;
    assign in_stall = !in_adv;

    always_comb
    begin
        in_valid_next  = in_adv ? in_valid : in_valid_reg;
        out_valid_next = out_adv ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            angle_x_reg <= angle_x;
            angle_y_reg <= angle_y;
        end
        if (out_adv && in_valid_reg)
        begin
            mat_reg <= mat;
        end
    end

    rmta_lookup u_lookup (
        .angle_x (angle_x_reg),
        .angle_y (angle_y_reg),
        .trig    (trig)
    );

    rmta_product u_product (
        .trig (trig),
        .mat  (mat)
    );

    assign out_valid = out_valid_reg;
    assign m00 = mat_reg.m00;
    assign m01 = mat_reg.m01;
    assign m02 = mat_reg.m02;
    assign m10 = mat_reg.m10;
    assign m11 = mat_reg.m11;
    assign m12 = mat_reg.m12;
    assign m20 = mat_reg.m20;
    assign m21 = mat_reg.m21;
    assign m22 = mat_reg.m22;

endmodule

[design/rmta_checker.sv]
// Port-level checks for the two-angle rotation matrix block, bound to its top.
// Depends on rotation_matrix_two_angles.
module rmta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [8:0]  angle_x,
    input logic [8:0]  angle_y,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] m00,
    input logic [15:0] m01,
    input logic [15:0] m11
);

    // A stalled output transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // Column one of row zero is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> m01 == 16'd0)
        else $error("m01 is not zero");

    // Zero angles give the near-identity diagonal once they pass the input and
    // result registers while the output is free to move.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && angle_x == 9'd0 && angle_y == 9'd0)
        ##1 !out_stall |=> out_valid && m00 == 16'd32766 && m11 == 16'd32766)
        else $error("identity rotation gave wrong diagonal");

endmodule

bind rotation_matrix_two_angles rmta_checker u_rmta_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .angle_x   (angle_x),
    .angle_y   (angle_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .m00       (m00),
    .m01       (m01),
    .m11       (m11)
);

[test/rotation_matrix_compare.sv]
// Watches both channels of rotation_matrix_two_angles, predicts each product
// matrix from its own degree sine table and compares entry by entry.
// Depends on rmta_pkg for the angle and matrix types.
module rotation_matrix_compare (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  rmta_pkg::angle_t angle_x,
    input  rmta_pkg::angle_t angle_y,
    input  logic             out_valid,
    input  logic             out_stall,
    input  rmta_pkg::q15_t   m00,
    input  rmta_pkg::q15_t   m01,
    input  rmta_pkg::q15_t   m02,
    input  rmta_pkg::q15_t   m10,
    input  rmta_pkg::q15_t   m11,
    input  rmta_pkg::q15_t   m12,
    input  rmta_pkg::q15_t   m20,
    input  rmta_pkg::q15_t   m21,
    input  rmta_pkg::q15_t   m22,
    output int               failures,
    output int               outstanding
);
    import rmta_pkg::*;

    typedef struct {
        angle_t  ax;
        angle_t  ay;
        matrix_t m;
    } angle_matrix_t;

    localparam string ENTRY_NAME [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                         "m20", "m21", "m22"};

    int            sine_deg [DEGREE_STEPS];
    angle_matrix_t matrices_due [$];
    angle_matrix_t head;
    q15_t          seen [9];
    q15_t          want;
    int            error_tally;

    // Taylor series of sin(d degrees), d in 0..90, unsigned Q30.
    function automatic longint unsigned quadrant_sine_q30(input int unsigned d);
        longint unsigned q;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        q    = (longint'(d) * 64'd3141592653589793) / 64'd180;
        hi   = q / 64'd1000000;
        lo   = q % 64'd1000000;
        x    = ((hi << 30) + ((lo << 30) / 64'd1000000)) / 64'd1000000000;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                neg += term;
            end else begin
                pos += term;
            end
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic int scaled_sine(input int d);
        int              r;
        bit              flip;
        longint unsigned mag;
        flip = (d > 180);
        if (d <= 90) begin
            r = d;
        end else if (d <= 180) begin
            r = 180 - d;
        end else if (d <= 270) begin
            r = d - 180;
        end else begin
            r = 360 - d;
        end
        mag = (quadrant_sine_q30(r) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return flip ? -int'(mag) : int'(mag);
    endfunction

    // Floor of a*b/2^15, which is what an arithmetic shift gives.
    function automatic longint q15_product(input int a, input int b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 15;
    endfunction

    function automatic matrix_t rotation_product(input angle_t ax_in, input angle_t ay_in);
        int      ax;
        int      ay;
        int      cx_idx;
        int      cy_idx;
        int      sx;
        int      cx;
        int      sy;
        int      cy;
        int      rx [3][3];
        int      ry [3][3];
        longint  acc;
        matrix_t res;
        ax = int'(ax_in);
        ay = int'(ay_in);
        // Angles past a full turn wrap once.
        if (ax >= int'(FULL_TURN)) ax -= int'(FULL_TURN);
        if (ay >= int'(FULL_TURN)) ay -= int'(FULL_TURN);
        cx_idx = int'(QUARTER_TURN) - ax;
        cy_idx = int'(QUARTER_TURN) - ay;
        if (cx_idx < 0) cx_idx += DEGREE_STEPS;
        if (cy_idx < 0) cy_idx += DEGREE_STEPS;
        sx = sine_deg[ax];
        cx = sine_deg[cx_idx];
        sy = sine_deg[ay];
        cy = sine_deg[cy_idx];
        rx = '{'{int'(Q15_ONE), 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, int'(Q15_ONE), 0}, '{-sy, 0, cy}};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) begin
                    acc += q15_product(rx[i][k], ry[k][j]);
                end
                res[(8 - (i * 3 + j)) * Q15_W +: Q15_W] = acc[Q15_W-1:0];
            end
        end
        return res;
    endfunction

    initial begin
        error_tally = 0;
        for (int d = 0; d < DEGREE_STEPS; d++) begin
            sine_deg[d] = scaled_sine(d);
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            matrices_due.delete();
            outstanding <= 0;
            failures    <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (matrices_due.size() == 0) begin
                    error_tally++;
                    $display("%0t: matrix emitted with none expected (m00 %0d)", $time, m00);
                end else begin
                    head = matrices_due.pop_front();
                    seen = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
                    for (int e = 0; e < 9; e++) begin
                        want = head.m[(8 - e) * Q15_W +: Q15_W];
                        if (seen[e] !== want) begin
                            error_tally++;
                            $display("%0t: angles %0d,%0d %s expected %0d actual %0d",
                                     $time, head.ax, head.ay, ENTRY_NAME[e], want, seen[e]);
                        end
                    end
                end
            end
            if (in_valid && !in_stall) begin
                matrices_due.push_back('{angle_x, angle_y, rotation_product(angle_x, angle_y)});
            end
            outstanding <= matrices_due.size();
            failures    <= error_tally;
        end
    end

endmodule

[test/tb_rotation_matrix_two_angles.sv]
// Top of the testbench for rotation_matrix_two_angles: clock, reset, angle
// stimulus with random gaps, random output stalls and the final verdict.
// Depends on rmta_pkg, the block and rotation_matrix_compare.
module tb_rotation_matrix_two_angles;
    import rmta_pkg::*;

    localparam int RANDOM_PAIRS = 1250;
    localparam int SEGMENT      = 125;
    localparam int DRAIN_CYCLES = 8;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    angle_t angle_x;
    angle_t angle_y;
    logic   out_valid;
    logic   out_stall;
    q15_t   m00, m01, m02, m10, m11, m12, m20, m21, m22;
    int     failures;
    int     outstanding;

    rotation_matrix_two_angles i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22)
    );

    // The compare module sees exactly what the block sees and reports its
    // mismatch count and the number of matrices still owed.
    rotation_matrix_compare i_compare (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .angle_x     (angle_x),
        .angle_y     (angle_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .m00         (m00),
        .m01         (m01),
        .m02         (m02),
        .m10         (m10),
        .m11         (m11),
        .m12         (m12),
        .m20         (m20),
        .m21         (m21),
        .m22         (m22),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle lengths: mostly none, often a few cycles, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Most angles are in the normal range. Some land on the quadrant edges,
    // where the cosine index wraps or the sine changes sign, and some fall in
    // 360..511, which the block folds back by one full turn.
    function automatic angle_t pick_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return angle_t'($urandom_range(DEGREE_STEPS, 511));
        if (r < 20) return angle_t'($urandom_range(0, 4) * 90 + $urandom_range(0, 1));
        return angle_t'($urandom_range(0, DEGREE_STEPS - 1));
    endfunction

    // Offer one pair and hold it until the block takes it. When a gap follows,
    // valid drops at the acceptance edge; otherwise it simply stays high and
    // the next call only changes the payload.
    task automatic send_angles(input angle_t ax, input angle_t ay, input int gap);
        in_valid <= 1'b1;
        angle_x  <= ax;
        angle_y  <= ay;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver side. Its stall pattern runs from its own cycle count: random
    // short stalls, occasional long ones, quiet windows with no stall at all,
    // and one long hold-off early on so that both registers fill and the
    // block has to push back on the sender.
    initial begin : sink
        int cycle_count;
        int hold_left;
        cycle_count = 0;
        hold_left   = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            cycle_count++;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (cycle_count == 400) begin
                hold_left = 150;
                out_stall <= 1'b1;
            end else if ((cycle_count / 256) % 4 == 1) begin
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 2) begin
                hold_left = $urandom_range(8, 40);
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 30);
            end
        end
    end

    // Sender side and verdict.
    initial begin : source
        // Directed pairs: zero and full-ones angles, every quadrant edge,
        // cosine indexes on both sides of the wrap, and angles past a full
        // turn, including the largest one the field can carry.
        static angle_t dir_x [] = '{9'd0,   9'd90,  9'd0,   9'd180, 9'd270, 9'd359, 9'd91,
                                    9'd89,  9'd45,  9'd135, 9'd225, 9'd315, 9'd360, 9'd449,
                                    9'd450, 9'd511, 9'd0,   9'd511, 9'd1,   9'd256, 9'd30};
        static angle_t dir_y [] = '{9'd0,   9'd0,   9'd90,  9'd270, 9'd180, 9'd359, 9'd89,
                                    9'd91,  9'd45,  9'd315, 9'd135, 9'd225, 9'd0,   9'd450,
                                    9'd449, 9'd511, 9'd511, 9'd0,   9'd255, 9'd1,   9'd60};
        bit gappy;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        angle_x  <= '0;
        angle_y  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part back to back, with no sender gaps.
        foreach (dir_x[i]) begin
            send_angles(dir_x[i], dir_y[i], 0);
        end

        // Random part, alternating segments with and without sender gaps.
        gappy = 1'b1;
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % SEGMENT == 0) gappy = ~gappy;
            send_angles(pick_angle(), pick_angle(), gappy ? idle_cycles() : 0);
        end
        in_valid <= 1'b0;

        // Wait for every owed matrix, then a few cycles for stray outputs.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Far beyond the slowest legal run; only a hung handshake gets here.
    initial begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
design/rmta_pkg.sv
design/rmta_lookup.sv
design/rmta_product.sv
design/rotation_matrix_two_angles.sv
design/rmta_checker.sv
test/rotation_matrix_compare.sv
test/tb_rotation_matrix_two_angles.sv
